### rtl/core/tridiagonal_solver_assert.svh
// assertion macros for the tridiagonal solver
// used by the top level only
`ifndef TRIDIAGONAL_SOLVER_ASSERT_SVH
`define TRIDIAGONAL_SOLVER_ASSERT_SVH
`define TDS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tds check failed");
`define TDS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tds check failed");
`endif

### rtl/core/tds_pkg.sv
// shared types and constants for the tridiagonal solver
// no dependencies
`timescale 1ns / 1ps
package tds_pkg;
    localparam int MaxRows = 64;
    localparam int DataWidth = 32;
    localparam int FracBits = 16;
    localparam int RowW = $clog2(MaxRows);
    localparam int CntW = RowW + 1;
    localparam int ProdW = 2 * DataWidth;
    localparam int NumW = DataWidth + FracBits;

    typedef logic signed [DataWidth-1:0] t_word;

    typedef struct packed {
        t_word sub_diagonal;
        t_word diagonal;
        t_word super_diagonal;
        t_word rhs;
        logic  last_row;
    } t_in;

    typedef struct packed {
        t_word           solution;
        logic [RowW-1:0] row_index;
        logic            pivot_error;
        logic            last_result;
    } t_out;

    typedef enum logic [3:0] {
        S_LOAD, S_FRD, S_FDIV, S_FMUL, S_FWR, S_BRD, S_BMUL, S_BDIV,
        S_BWR, S_EMIT, S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic            load;
        logic [RowW-1:0] rd_row;
        logic            fwd_div;
        logic            fwd_mul;
        logic            fwd_wr;
        logic            bwd_mul;
        logic            bwd_div;
        logic            bwd_wr;
        logic            clr_err;
        logic [RowW-1:0] row;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_busy;
    } t_sts;

    function automatic t_word sat(input logic signed [ProdW:0] v);
        logic signed [ProdW:0] hi;
        logic signed [ProdW:0] lo;
        hi = (ProdW+1)'(signed'({1'b0, {(DataWidth-1){1'b1}}}));
        lo = -hi - 1;
        if (v > hi) return t_word'(hi);
        if (v < lo) return t_word'(lo);
        return t_word'(v);
    endfunction
endpackage

### rtl/core/tds_if.sv
// valid/ready channel carrying one payload
// no dependencies, the payload type is a parameter
`timescale 1ns / 1ps
interface tds_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/tds_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps
module tds_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/tds_div.sv
// iterative signed fixed point divider, one quotient bit per cycle
// depends on tds_pkg
`timescale 1ns / 1ps
module tds_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tds_pkg::t_word i_num,
    input  tds_pkg::t_word i_den,
    output logic          o_busy,
    output tds_pkg::t_word o_quot,
    output logic          o_zero
);
    import tds_pkg::*;
    localparam int StepW = $clog2(NumW + 1);

    logic [NumW-1:0]      r_q, n_q;
    logic [DataWidth:0]   r_rem, n_rem;
    logic [DataWidth-1:0] r_den;
    logic                 r_neg;
    logic [StepW-1:0]     r_cnt;
    logic                 r_busy;
    logic [DataWidth:0]   w_trial;
    logic [NumW-1:0]      w_nabs;
    logic signed [ProdW:0] w_sq;

    assign w_nabs = i_num[DataWidth-1] ? NumW'(-{{FracBits{i_num[DataWidth-1]}}, i_num})
                                       : NumW'({{FracBits{1'b0}}, i_num});
    assign w_trial = {r_rem[DataWidth-1:0], r_q[NumW-1]};

    always_comb begin
        n_q = {r_q[NumW-2:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= (i_den != '0);
            r_cnt <= StepW'(NumW);
            r_q <= {w_nabs[NumW-1-FracBits:0], {FracBits{1'b0}}};
            r_rem <= '0;
            r_den <= i_den[DataWidth-1] ? DataWidth'(-i_den) : i_den;
            r_neg <= i_num[DataWidth-1] ^ i_den[DataWidth-1];
            o_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_q <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == StepW'(1)) r_busy <= 1'b0;
        end
    end

    assign w_sq = r_neg ? -(ProdW+1)'($unsigned(r_q)) : (ProdW+1)'($unsigned(r_q));
    assign o_quot = o_zero ? '0 : sat(w_sq);
    assign o_busy = r_busy;
endmodule

### rtl/core/tds_dp.sv
// datapath: row stores, multipliers, divider and result register
// depends on tds_pkg, tds_ram, tds_div
`timescale 1ns / 1ps
module tds_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tds_pkg::t_cmd i_cmd,
    input  tds_pkg::t_in  i_row,
    output tds_pkg::t_sts o_sts,
    output tds_pkg::t_word o_x,
    output logic          o_err
);
    import tds_pkg::*;

    t_word w_sub, w_dg, w_sup, w_rhs, w_dgp, w_supp, w_rhsp;
    t_word w_ratio, r_x;
    t_word w_q;
    t_word w_ma, w_mb;
    logic  w_busy, w_zero, r_err;
    logic [RowW-1:0] w_prev;
    t_word w_dwr, w_rwr;
    logic  w_dwe, w_rwe;
    logic signed [ProdW-1:0] w_p1, w_p2;
    logic signed [ProdW-1:0] w_t1, w_t2;
    logic signed [ProdW-1:0] r_prod1, r_prod2;
    logic signed [ProdW:0] w_d1, w_d2;
    t_word w_num, w_den;
    logic  w_start;

    assign w_prev = i_cmd.rd_row - 1'b1;

    // current row stores read at rd_row, previous row mirrors at rd_row-1
    tds_ram #(.Width(DataWidth), .Depth(MaxRows)) u_sub (.i_clk, .i_we(i_cmd.load),
        .i_waddr(i_cmd.row), .i_wdata(i_row.sub_diagonal), .i_raddr(i_cmd.rd_row),
        .o_rdata(w_sub));
    tds_ram #(.Width(DataWidth), .Depth(MaxRows)) u_dg (.i_clk, .i_we(w_dwe),
        .i_waddr(i_cmd.row), .i_wdata(w_dwr), .i_raddr(i_cmd.rd_row), .o_rdata(w_dg));
    tds_ram #(.Width(DataWidth), .Depth(MaxRows)) u_dgp (.i_clk, .i_we(w_dwe),
        .i_waddr(i_cmd.row), .i_wdata(w_dwr), .i_raddr(w_prev), .o_rdata(w_dgp));
    tds_ram #(.Width(DataWidth), .Depth(MaxRows)) u_sup (.i_clk, .i_we(i_cmd.load),
        .i_waddr(i_cmd.row), .i_wdata(i_row.super_diagonal), .i_raddr(i_cmd.rd_row),
        .o_rdata(w_sup));
    tds_ram #(.Width(DataWidth), .Depth(MaxRows)) u_supp (.i_clk, .i_we(i_cmd.load),
        .i_waddr(i_cmd.row), .i_wdata(i_row.super_diagonal), .i_raddr(w_prev),
        .o_rdata(w_supp));
    tds_ram #(.Width(DataWidth), .Depth(MaxRows)) u_rhs (.i_clk, .i_we(w_rwe),
        .i_waddr(i_cmd.row), .i_wdata(w_rwr), .i_raddr(i_cmd.rd_row), .o_rdata(w_rhs));
    tds_ram #(.Width(DataWidth), .Depth(MaxRows)) u_rhsp (.i_clk, .i_we(w_rwe),
        .i_waddr(i_cmd.row), .i_wdata(w_rwr), .i_raddr(w_prev), .o_rdata(w_rhsp));

    assign w_dwe = i_cmd.load || i_cmd.fwd_wr;
    assign w_rwe = i_cmd.load || i_cmd.fwd_wr;
    assign w_dwr = i_cmd.load ? i_row.diagonal : sat(w_d1);
    assign w_rwr = i_cmd.load ? i_row.rhs : sat(w_d2);

    // ratio holds at the divider output once it finishes
    assign w_ratio = w_q;

    // products truncate toward zero and stay full width until the difference
    assign w_ma = i_cmd.fwd_mul ? w_ratio : w_sup;
    assign w_mb = i_cmd.fwd_mul ? w_rhsp : r_x;
    assign w_p1 = ProdW'(w_ratio) * ProdW'(w_supp);
    assign w_p2 = ProdW'(w_ma) * ProdW'(w_mb);
    assign w_t1 = (w_p1 < 0) ? -((-w_p1) >>> FracBits) : (w_p1 >>> FracBits);
    assign w_t2 = (w_p2 < 0) ? -((-w_p2) >>> FracBits) : (w_p2 >>> FracBits);
    assign w_d1 = (ProdW+1)'(w_dg) - (ProdW+1)'(r_prod1);
    assign w_d2 = (ProdW+1)'(w_rhs) - (ProdW+1)'(r_prod2);

    assign w_start = i_cmd.fwd_div || i_cmd.bwd_div;
    assign w_num = i_cmd.fwd_div ? w_sub : sat(w_d2);
    assign w_den = i_cmd.fwd_div ? w_dgp : w_dg;

    tds_div u_div (.i_clk, .i_rst_n, .i_start(w_start), .i_num(w_num), .i_den(w_den),
        .o_busy(w_busy), .o_quot(w_q), .o_zero(w_zero));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else begin
            if (i_cmd.clr_err) r_err <= 1'b0;
            else if ((i_cmd.fwd_wr || i_cmd.bwd_wr) && w_zero) r_err <= 1'b1;
        end
        if (i_cmd.fwd_mul || i_cmd.bwd_mul) begin
            r_prod1 <= w_t1;
            r_prod2 <= w_t2;
        end
        // the last row has no right neighbor, so its product term is zero
        if (i_cmd.clr_err) r_x <= '0;
        else if (i_cmd.bwd_wr) r_x <= w_q;
    end

    assign o_sts = '{div_busy: w_busy || w_start};
    assign o_x = r_x;
    assign o_err = r_err || (i_cmd.bwd_wr && w_zero);
endmodule

### rtl/core/tds_ctrl.sv
// controller state machine sequencing load, elimination, substitution, output
// depends on tds_pkg
`timescale 1ns / 1ps
module tds_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [tds_pkg::RowW-1:0] o_out_row,
    input  tds_pkg::t_sts i_sts,
    output tds_pkg::t_cmd o_cmd
);
    import tds_pkg::*;

    t_state r_st, n_st;
    logic [CntW-1:0] r_n, n_n;
    logic [CntW-1:0] r_i, n_i;
    logic r_go, n_go;
    logic w_acc;

    assign w_acc = i_in_valid && o_in_ready;

    always_comb begin
        n_st = r_st;
        n_n = r_n;
        n_i = r_i;
        unique case (r_st)
            S_LOAD: if (w_acc) begin
                if (r_n != CntW'(MaxRows)) n_n = r_n + 1'b1;
                if (i_in_last) begin
                    n_i = CntW'(1);
                    n_st = S_FRD;
                end
            end
            S_FRD: begin
                if (r_i >= r_n) begin
                    // back substitution starts at the last row held
                    n_i = r_n - 1'b1;
                    n_st = S_BRD;
                end else begin
                    n_st = S_FDIV;
                end
            end
            S_FDIV: if (!i_sts.div_busy) n_st = S_FMUL;
            S_FMUL: n_st = S_FWR;
            S_FWR: begin
                n_i = r_i + 1'b1;
                n_st = S_FRD;
            end
            S_BRD: n_st = S_BMUL;
            S_BMUL: n_st = S_BDIV;
            S_BDIV: if (!i_sts.div_busy) n_st = S_BWR;
            S_BWR: n_st = S_EMIT;
            S_EMIT: n_st = S_OUT;
            S_OUT: if (i_out_ready) begin
                if (r_i == '0) begin
                    n_n = '0;
                    n_st = S_LOAD;
                end else begin
                    n_i = r_i - 1'b1;
                    n_st = S_BRD;
                end
            end
            default: n_st = S_LOAD;
        endcase
        // divider starts on the first cycle of a divide state
        n_go = (n_st != r_st) && (n_st == S_FDIV || n_st == S_BDIV);
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.row = r_n[RowW-1:0];
        o_cmd.rd_row = r_i[RowW-1:0];
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_st)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && (r_n != CntW'(MaxRows));
                o_cmd.clr_err = w_acc && i_in_last;
            end
            S_FDIV: o_cmd.fwd_div = r_go;
            S_FMUL: o_cmd.fwd_mul = 1'b1;
            S_FWR: begin
                o_cmd.fwd_wr = 1'b1;
                o_cmd.row = r_i[RowW-1:0];
            end
            S_BMUL: o_cmd.bwd_mul = 1'b1;
            S_BDIV: o_cmd.bwd_div = r_go;
            S_BWR: begin
                o_cmd.bwd_wr = 1'b1;
                o_cmd.row = r_i[RowW-1:0];
            end
            S_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
        o_out_row = r_i[RowW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_n <= '0;
            r_i <= '0;
            r_go <= 1'b0;
        end else begin
            r_st <= n_st;
            r_n <= n_n;
            r_i <= n_i;
            r_go <= n_go;
        end
    end
endmodule

### rtl/core/tridiagonal_solver.sv
// Tridiagonal solver, signed Q16.16. Rows are taken one per transfer, with
// ready held high while loading. The row marked last starts the solve: rows
// are eliminated, then back-substituted, each waiting on the shared
// one-bit-per-cycle divider (48 steps per divide, none on a zero pivot), and a
// back-substituted row also waits until its result is taken. Each solution is
// shown from the last row down to row 0. No rows are accepted until row 0
// has been transferred out.
`timescale 1ns / 1ps
`include "tridiagonal_solver_assert.svh"
module tridiagonal_solver (
    input  logic i_clk,
    input  logic i_rst_n,
    tds_if.sink   i_row,
    tds_if.source o_res
);
    import tds_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    t_word w_x;
    logic w_err;
    logic [RowW-1:0] w_orow;
    t_in w_in;

    assign w_in = i_row.data;

    tds_ctrl u_ctrl (.i_clk, .i_rst_n, .i_in_valid(i_row.valid), .i_in_last(w_in.last_row),
        .o_in_ready(i_row.ready), .i_out_ready(o_res.ready), .o_out_valid(o_res.valid),
        .o_out_row(w_orow), .i_sts(w_sts), .o_cmd(w_cmd));
    tds_dp u_dp (.i_clk, .i_rst_n, .i_cmd(w_cmd), .i_row(w_in), .o_sts(w_sts),
        .o_x(w_x), .o_err(w_err));

    assign o_res.data = '{solution: w_x, row_index: w_orow, pivot_error: w_err,
                          last_result: (w_orow == '0)};

    `TDS_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_res.valid, !i_row.ready)
    `TDS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid)
endmodule

### bench/tds_checker.sv
// scoreboard for the tridiagonal solver: watches row and result transfers,
// predicts every solution component and compares; depends on tds_pkg
`timescale 1ns / 1ps
module tds_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_row_valid,
    input  logic          i_row_ready,
    input  tds_pkg::t_in  i_row,
    input  logic          i_res_valid,
    input  logic          i_res_ready,
    input  tds_pkg::t_out i_res,
    output int            o_errors,
    output int            o_waiting,
    output int            o_solves,
    output int            o_results
);
    import tds_pkg::*;

    localparam longint WordMax = (64'sd1 <<< (DataWidth - 1)) - 1;
    localparam longint WordMin = -WordMax - 1;
    localparam longint OneQ = 64'sd1 <<< FracBits;

    longint sub_m [MaxRows];
    longint dia_m [MaxRows];
    longint sup_m [MaxRows];
    longint rhs_m [MaxRows];
    int     rows_held;
    t_out   solution_q [$];

    initial begin
        o_errors = 0;
        o_solves = 0;
        o_results = 0;
        rows_held = 0;
    end

    assign o_waiting = solution_q.size();

    task automatic report(input string what, input longint got, input longint want);
        o_errors++;
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic longint clamp_word(input longint v);
        if (v > WordMax) return WordMax;
        if (v < WordMin) return WordMin;
        return v;
    endfunction

    // a - b*c, product truncated toward zero
    function automatic longint minus_product(input longint a, input longint b,
                                             input longint c);
        return clamp_word(a - (b * c) / OneQ);
    endfunction

    function automatic longint quotient(input longint num, input longint den,
                                        inout bit zero_pivot);
        if (den == 0) begin
            zero_pivot = 1'b1;
            return 0;
        end
        return clamp_word((num * OneQ) / den);
    endfunction

    task automatic solve_system();
        longint xs [MaxRows];
        longint ratio;
        longint t;
        bit     zero_pivot;
        t_out   r;
        int     n;
        n = rows_held;
        zero_pivot = 1'b0;
        for (int i = 1; i < n; i++) begin
            ratio = quotient(sub_m[i], dia_m[i-1], zero_pivot);
            dia_m[i] = minus_product(dia_m[i], ratio, sup_m[i-1]);
            rhs_m[i] = minus_product(rhs_m[i], ratio, rhs_m[i-1]);
        end
        xs[n-1] = quotient(rhs_m[n-1], dia_m[n-1], zero_pivot);
        for (int i = n - 1; i > 0; i--) begin
            t = minus_product(rhs_m[i-1], sup_m[i-1], xs[i]);
            xs[i-1] = quotient(t, dia_m[i-1], zero_pivot);
        end
        for (int i = n - 1; i >= 0; i--) begin
            r.solution = t_word'(xs[i]);
            r.row_index = RowW'(i);
            r.pivot_error = zero_pivot;
            r.last_result = (i == 0);
            solution_q.push_back(r);
        end
        rows_held = 0;
        o_solves++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_row_valid && i_row_ready) begin
                // rows past a full store are dropped, a last flag still counts
                if (rows_held < MaxRows) begin
                    sub_m[rows_held] = longint'(i_row.sub_diagonal);
                    dia_m[rows_held] = longint'(i_row.diagonal);
                    sup_m[rows_held] = longint'(i_row.super_diagonal);
                    rhs_m[rows_held] = longint'(i_row.rhs);
                    rows_held++;
                end
                if (i_row.last_row)
                    solve_system();
            end
            if (i_res_valid && i_res_ready) begin
                o_results++;
                if (solution_q.size() == 0) begin
                    report("result with nothing pending, row", i_res.row_index, -1);
                end else begin
                    want = solution_q.pop_front();
                    if (i_res.solution !== want.solution)
                        report("solution", i_res.solution, want.solution);
                    if (i_res.row_index !== want.row_index)
                        report("row_index", i_res.row_index, want.row_index);
                    if (i_res.pivot_error !== want.pivot_error)
                        report("pivot_error", i_res.pivot_error, want.pivot_error);
                    if (i_res.last_result !== want.last_result)
                        report("last_result", i_res.last_result, want.last_result);
                end
            end
        end
    end
endmodule

### bench/tb_tridiagonal_solver.sv
// testbench top for the tridiagonal solver: drives systems of rows, stalls
// the result side, gives the verdict; depends on tds_pkg, tds_if, tds_checker
`timescale 1ns / 1ps
module tb_tridiagonal_solver;
    import tds_pkg::*;

    typedef enum int {ROW_TAME, ROW_WILD, ROW_ZERO} t_row_kind;

    logic i_clk;
    logic i_rst_n;
    logic row_took;
    bit   calm;
    bit   hold_req;
    int   rows_sent;
    int   errors;
    int   waiting;
    int   solves;
    int   results;

    tds_if #(.T(t_in))  row_ch ();
    tds_if #(.T(t_out)) res_ch ();

    tridiagonal_solver u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_row  (row_ch.sink),
        .o_res  (res_ch.source)
    );

    tds_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_row_valid(row_ch.valid),
        .i_row_ready(row_ch.ready),
        .i_row      (row_ch.data),
        .i_res_valid(res_ch.valid),
        .i_res_ready(res_ch.ready),
        .i_res      (res_ch.data),
        .o_errors   (errors),
        .o_waiting  (waiting),
        .o_solves   (solves),
        .o_results  (results)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) row_took <= row_ch.valid && row_ch.ready;

    initial begin
        #5ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

    // random Q16.16 value in [-lim, lim) units
    function automatic t_word q_rand(input int lim);
        return t_word'(int'($urandom_range(0, 2 * lim * 65536 - 1)) - lim * 65536);
    endfunction

    function automatic t_in make_row(input t_row_kind kind, input bit last);
        t_in r;
        case (kind)
            ROW_TAME: begin
                r.sub_diagonal = q_rand(2);
                r.super_diagonal = q_rand(2);
                r.diagonal = t_word'($urandom_range(5 * 65536, 12 * 65536));
                if ($urandom_range(0, 1)) r.diagonal = -r.diagonal;
                r.rhs = q_rand(50);
            end
            ROW_WILD: begin
                r.sub_diagonal = t_word'($urandom);
                r.diagonal = t_word'($urandom);
                r.super_diagonal = t_word'($urandom);
                r.rhs = t_word'($urandom);
            end
            default: begin
                r.sub_diagonal = q_rand(4);
                r.diagonal = '0;
                r.super_diagonal = q_rand(4);
                r.rhs = q_rand(100);
            end
        endcase
        r.last_row = last;
        return r;
    endfunction

    task automatic send_row(input t_in r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            row_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        row_ch.valid <= 1'b1;
        row_ch.data <= r;
        do @(negedge i_clk); while (!row_took);
        rows_sent++;
    endtask

    // zero_at < 0 means no forced zero pivot row
    task automatic send_system(input int n, input t_row_kind kind, input int zero_at);
        for (int i = 0; i < n; i++)
            send_row(make_row(i == zero_at ? ROW_ZERO : kind, i == n - 1));
    endtask

    // result side: random ready bursts, one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (800) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (calm || $urandom_range(0, 2) != 0) begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
        end
    end

    initial begin
        t_in r;
        int  n;
        int  drain;
        row_ch.valid = 1'b0;
        row_ch.data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        rows_sent = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single row, normal and with a zero diagonal
        send_system(1, ROW_TAME, -1);
        send_system(1, ROW_TAME, 0);
        // field extremes, forcing saturation everywhere
        r = '{sub_diagonal: 32'sh8000_0000, diagonal: 32'sh7fff_ffff,
              super_diagonal: 32'sh8000_0000, rhs: 32'sh7fff_ffff, last_row: 1'b0};
        send_row(r);
        r = '{sub_diagonal: 32'sh7fff_ffff, diagonal: 32'sh8000_0000,
              super_diagonal: 32'sh7fff_ffff, rhs: 32'sh8000_0000, last_row: 1'b1};
        send_row(r);
        r = '{sub_diagonal: 32'sh7fff_ffff, diagonal: 32'sh0000_0001,
              super_diagonal: '1, rhs: 32'sh8000_0000, last_row: 1'b0};
        send_row(r);
        r = '{sub_diagonal: '1, diagonal: '1, super_diagonal: '0, rhs: '1,
              last_row: 1'b1};
        send_row(r);
        // zero pivot at the top and in the middle of a system
        send_system(3, ROW_TAME, 0);
        send_system(4, ROW_TAME, 2);
        send_system(4, ROW_TAME, -1);
        send_system(4, ROW_WILD, -1);

        // random systems, mostly well conditioned
        while (rows_sent < 330) begin
            if (solves == 20 && !hold_req) begin
                // stall results while rows keep coming
                hold_req = 1'b1;
                send_system(5, ROW_TAME, -1);
                send_system(3, ROW_TAME, -1);
                send_system(2, ROW_TAME, -1);
            end
            if (solves == 35) begin
                // one more row than the store holds, plus a spare
                send_system(MaxRows + 2, ROW_TAME, -1);
                continue;
            end
            if (rows_sent > 280) calm = 1'b1;
            n = $urandom_range(1, 8);
            case ($urandom_range(0, 9))
                0, 1: send_system(n, ROW_WILD, -1);
                2: send_system(n, ROW_TAME, $urandom_range(0, n - 1));
                default: send_system(n, ROW_TAME, -1);
            endcase
        end
        row_ch.valid <= 1'b0;

        drain = 0;
        while (waiting != 0 && drain < 200000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (200) @(negedge i_clk);
        $display("sent %0d rows in %0d systems, %0d solution components checked",
                 rows_sent, solves, results);
        $display("covered saturation, zero pivots, a full row store and a long result stall");
        if (errors == 0 && waiting == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, waiting);
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
